// File: hw/rtl/sism_pkg.sv
// ----------------------------------------------------------------------------
// sism_pkg
// Shared types and constants for the sorted interval set with merge.
// ----------------------------------------------------------------------------
package sism_pkg;

  // list depth and stored time width
  localparam int MAX_INTERVALS = 64;
  localparam int TIME_BITS     = 31;

  // port field widths
  localparam int OP_W     = 2;
  localparam int TIME_W   = 31;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  // derived widths: index into the list, and a count that can hold the depth
  localparam int IDX_BITS = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CNT_BITS = $clog2(MAX_INTERVALS + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // one stored interval
  typedef struct packed {
    time_t t_start;
    time_t t_end;
  } entry_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_REVERSED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINAL,
    S_RD_WAIT,
    S_FINISH
  } state_e;

endpackage

// File: hw/rtl/sorted_interval_set_merge.sv
// ----------------------------------------------------------------------------
// sorted_interval_set_merge
// Sorted list of disjoint closed intervals with insert-and-merge, read by
// index and clear. The list lives in one synchronous memory.
// ----------------------------------------------------------------------------
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------------------------------
//  in      | in_valid_i | in_stall_o  | op, start_time, end_time, entry_index
//  out     | out_valid_o| out_stall_i | status, interval_start, interval_end,
//          |            |             | interval_pos, stored_count
//
//  An insert streams one memory read per cycle through the list until the
//  slot is found, then streams one read and one write per cycle to open or
//  close a gap, so the list is passed over about once. A read waits on the
//  registered memory read; clear, no-op, a reversed insert and a read beyond
//  the count skip the memory and go straight to the result. The single memory
//  port pair sets the pace of these steps. One item is in work at a time.
//  Reset empties the list at once (count to zero); entries are not cleared.
//  A stalled output holds its item; the block finishes the next item into a
//  staging register and waits there until the output register frees up.
//
module sorted_interval_set_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sism_pkg::OP_W-1:0]      op_i,
  input  logic [sism_pkg::TIME_W-1:0]    start_time_i,
  input  logic [sism_pkg::TIME_W-1:0]    end_time_i,
  input  logic [sism_pkg::POS_W-1:0]     entry_index_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sism_pkg::STATUS_W-1:0]  status_o,
  output logic [sism_pkg::TIME_W-1:0]    interval_start_o,
  output logic [sism_pkg::TIME_W-1:0]    interval_end_o,
  output logic [sism_pkg::POS_W-1:0]     interval_pos_o,
  output logic [sism_pkg::COUNT_W-1:0]   stored_count_o
);

  // interval memory
  sism_pkg::entry_t ivl_mem [sism_pkg::MAX_INTERVALS];
  sism_pkg::entry_t rd_data_q;
  sism_pkg::idx_t   mem_raddr;
  sism_pkg::idx_t   mem_waddr;
  sism_pkg::entry_t mem_wdata;
  logic             mem_we;

  // control state
  sism_pkg::state_e state_q, state_d;
  sism_pkg::cnt_t   held_q, held_d;
  logic             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;

  // working registers
  sism_pkg::time_t  s_q, s_d;
  sism_pkg::time_t  e_q, e_d;
  sism_pkg::time_t  ms_q, ms_d;
  sism_pkg::time_t  me_q, me_d;
  sism_pkg::cnt_t   rptr_q, rptr_d;
  sism_pkg::cnt_t   chk_q, chk_d;
  sism_pkg::cnt_t   i_q, i_d;
  sism_pkg::cnt_t   k_q, k_d;
  sism_pkg::cnt_t   rem_q, rem_d;
  sism_pkg::cnt_t   delta_q, delta_d;
  sism_pkg::cnt_t   cnt_new_q, cnt_new_d;

  // staged result
  sism_pkg::status_e res_status_q, res_status_d;
  sism_pkg::time_t   res_start_q, res_start_d;
  sism_pkg::time_t   res_end_q, res_end_d;
  sism_pkg::cnt_t    res_pos_q, res_pos_d;

  // output register
  logic [sism_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [sism_pkg::TIME_W-1:0]   out_start_q, out_start_d;
  logic [sism_pkg::TIME_W-1:0]   out_end_q, out_end_d;
  logic [sism_pkg::POS_W-1:0]    out_pos_q, out_pos_d;
  logic [sism_pkg::COUNT_W-1:0]  out_count_q, out_count_d;

  // shared conditions
  sism_pkg::time_t in_s, in_e;
  logic            in_take;
  logic            in_reversed;
  logic            rd_beyond;
  logic            scan_more;
  logic            list_full;
  logic            hit;
  logic            gap;
  logic            out_free;
  sism_pkg::cnt_t  merge_j;

  assign in_s        = sism_pkg::time_t'(start_time_i);
  assign in_e        = sism_pkg::time_t'(end_time_i);
  assign in_take     = in_valid_i && (state_q == sism_pkg::S_IDLE);
  assign in_reversed = in_s > in_e;
  assign rd_beyond   = int'(entry_index_i) >= int'(held_q);
  assign scan_more   = rptr_q < held_q;
  assign list_full   = held_q >= sism_pkg::cnt_t'(sism_pkg::MAX_INTERVALS);
  // entry under test ends at or after new start / new end lies before it
  assign hit         = rd_data_q.t_end >= s_q;
  assign gap         = e_q < rd_data_q.t_start;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign merge_j     = pend_q ? chk_q : held_q;

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ivl_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= ivl_mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sism_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            sism_pkg::OP_INSERT: state_d = in_reversed ? sism_pkg::S_FINISH
                                                       : sism_pkg::S_SCAN;
            sism_pkg::OP_READ:   state_d = rd_beyond ? sism_pkg::S_FINISH
                                                     : sism_pkg::S_RD_WAIT;
            default:             state_d = sism_pkg::S_FINISH;
          endcase
        end
      end
      sism_pkg::S_SCAN: begin
        if (pend_q && hit) begin
          if (!gap) begin
            state_d = sism_pkg::S_MERGE;
          end else if (list_full) begin
            state_d = sism_pkg::S_FINISH;
          end else begin
            state_d = sism_pkg::S_SHIFT_UP;
          end
        end else if (!pend_q && !scan_more) begin
          state_d = list_full ? sism_pkg::S_FINISH : sism_pkg::S_FINAL;
        end
      end
      sism_pkg::S_MERGE: begin
        if (!pend_q || gap) begin
          state_d = (merge_j == i_q + sism_pkg::cnt_t'(1)) ? sism_pkg::S_FINAL
                                                            : sism_pkg::S_SHIFT_DN;
        end
      end
      sism_pkg::S_SHIFT_UP,
      sism_pkg::S_SHIFT_DN: begin
        if (!pend_q && rem_q == '0) begin
          state_d = sism_pkg::S_FINAL;
        end
      end
      sism_pkg::S_FINAL:   state_d = sism_pkg::S_FINISH;
      sism_pkg::S_RD_WAIT: state_d = sism_pkg::S_FINISH;
      sism_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = sism_pkg::S_IDLE;
        end
      end
      default: state_d = sism_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    held_d       = held_q;
    pend_d       = 1'b0;
    s_d          = s_q;
    e_d          = e_q;
    ms_d         = ms_q;
    me_d         = me_q;
    rptr_d       = rptr_q;
    chk_d        = chk_q;
    i_d          = i_q;
    k_d          = k_q;
    rem_d        = rem_q;
    delta_d      = delta_q;
    cnt_new_d    = cnt_new_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_end_d    = res_end_q;
    res_pos_d    = res_pos_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_end_d    = out_end_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    mem_raddr    = rptr_q[sism_pkg::IDX_BITS-1:0];
    mem_waddr    = i_q[sism_pkg::IDX_BITS-1:0];
    mem_wdata    = rd_data_q;
    mem_we       = 1'b0;

    case (state_q)
      // take an item, settle the quick cases
      sism_pkg::S_IDLE: begin
        mem_raddr = sism_pkg::idx_t'(entry_index_i);
        if (in_take) begin
          s_d          = in_s;
          e_d          = in_e;
          rptr_d       = '0;
          res_status_d = sism_pkg::ST_OK;
          res_start_d  = '0;
          res_end_d    = '0;
          res_pos_d    = '0;
          case (op_i)
            sism_pkg::OP_INSERT: begin
              if (in_reversed) begin
                res_status_d = sism_pkg::ST_REVERSED;
              end
            end
            sism_pkg::OP_READ: begin
              if (rd_beyond) begin
                res_status_d = sism_pkg::ST_RANGE;
              end else begin
                res_pos_d = sism_pkg::cnt_t'(entry_index_i);
              end
            end
            sism_pkg::OP_CLEAR: held_d = '0;
            default: ;
          endcase
        end
      end

      // stream reads, find first entry ending at or after new start
      sism_pkg::S_SCAN: begin
        if (scan_more) begin
          rptr_d = rptr_q + sism_pkg::cnt_t'(1);
          pend_d = 1'b1;
          chk_d  = rptr_q;
        end
        if (pend_q && hit) begin
          i_d = chk_q;
          if (!gap) begin
            ms_d = (s_q < rd_data_q.t_start) ? s_q : rd_data_q.t_start;
            me_d = (e_q > rd_data_q.t_end) ? e_q : rd_data_q.t_end;
          end else if (list_full) begin
            res_status_d = sism_pkg::ST_FULL;
          end else begin
            ms_d      = s_q;
            me_d      = e_q;
            k_d       = held_q - sism_pkg::cnt_t'(1);
            rem_d     = held_q - chk_q;
            pend_d    = 1'b0;
            cnt_new_d = held_q + sism_pkg::cnt_t'(1);
          end
        end else if (!pend_q && !scan_more) begin
          if (list_full) begin
            res_status_d = sism_pkg::ST_FULL;
          end else begin
            i_d       = held_q;
            ms_d      = s_q;
            me_d      = e_q;
            cnt_new_d = held_q + sism_pkg::cnt_t'(1);
          end
        end
      end

      // absorb following entries that start at or before the new end
      sism_pkg::S_MERGE: begin
        if (scan_more) begin
          rptr_d = rptr_q + sism_pkg::cnt_t'(1);
          pend_d = 1'b1;
          chk_d  = rptr_q;
        end
        if (pend_q && !gap) begin
          me_d = (me_q > rd_data_q.t_end) ? me_q : rd_data_q.t_end;
        end else begin
          delta_d   = merge_j - i_q - sism_pkg::cnt_t'(1);
          k_d       = merge_j;
          rem_d     = held_q - merge_j;
          pend_d    = 1'b0;
          cnt_new_d = held_q - (merge_j - i_q - sism_pkg::cnt_t'(1));
        end
      end

      // move entries i..n-1 up by one, top first
      sism_pkg::S_SHIFT_UP: begin
        mem_raddr = k_q[sism_pkg::IDX_BITS-1:0];
        if (rem_q != '0) begin
          k_d    = k_q - sism_pkg::cnt_t'(1);
          rem_d  = rem_q - sism_pkg::cnt_t'(1);
          pend_d = 1'b1;
          chk_d  = k_q;
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = sism_pkg::idx_t'(chk_q + sism_pkg::cnt_t'(1));
        end
      end

      // move entries j..n-1 down over the absorbed ones
      sism_pkg::S_SHIFT_DN: begin
        mem_raddr = k_q[sism_pkg::IDX_BITS-1:0];
        if (rem_q != '0) begin
          k_d    = k_q + sism_pkg::cnt_t'(1);
          rem_d  = rem_q - sism_pkg::cnt_t'(1);
          pend_d = 1'b1;
          chk_d  = k_q;
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = sism_pkg::idx_t'(chk_q - delta_q);
        end
      end

      // write the new or merged entry
      sism_pkg::S_FINAL: begin
        mem_we       = 1'b1;
        mem_waddr    = i_q[sism_pkg::IDX_BITS-1:0];
        mem_wdata    = '{t_start: ms_q, t_end: me_q};
        held_d       = cnt_new_q;
        res_status_d = sism_pkg::ST_OK;
        res_start_d  = ms_q;
        res_end_d    = me_q;
        res_pos_d    = i_q;
      end

      sism_pkg::S_RD_WAIT: begin
        res_start_d = rd_data_q.t_start;
        res_end_d   = rd_data_q.t_end;
      end

      // hand the result to the output register
      sism_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = sism_pkg::TIME_W'(res_start_q);
          out_end_d    = sism_pkg::TIME_W'(res_end_q);
          out_pos_d    = sism_pkg::POS_W'(res_pos_q);
          out_count_d  = sism_pkg::COUNT_W'(held_q);
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sism_pkg::S_IDLE;
      held_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    e_q          <= e_d;
    ms_q         <= ms_d;
    me_q         <= me_d;
    rptr_q       <= rptr_d;
    chk_q        <= chk_d;
    i_q          <= i_d;
    k_q          <= k_d;
    rem_q        <= rem_d;
    delta_q      <= delta_d;
    cnt_new_q    <= cnt_new_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_end_q    <= res_end_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_end_q    <= out_end_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o       = state_q != sism_pkg::S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign interval_start_o = out_start_q;
  assign interval_end_o   = out_end_q;
  assign interval_pos_o   = out_pos_q;
  assign stored_count_o   = out_count_q;

endmodule
